@@ rtl/ffba_pkg.sv @@
// Shared types, constants and codes for the first-fit block allocator.
package ffba_pkg;

	localparam int MAX_BLOCKS      = 64;
	localparam int IDX_W           = $clog2(MAX_BLOCKS);
	localparam int LINK_W          = IDX_W + 1;
	localparam int MIN_SPLIT_EXTRA = 4;

	localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_BLOCKS);
	localparam logic [LINK_W-1:0] WALK_LIMIT = LINK_W'(MAX_BLOCKS);

	localparam logic [31:0] HEAP_TOP_RESET    = 32'hFFFE_FFFB;
	localparam logic [31:0] HEAP_FLOOR_RESET  = 32'h0000_0000;
	localparam logic [4:0]  HEADER_SIZE_RESET = 5'd3;

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_AUTO    = 2'd1;
	localparam logic [1:0] CMD_FREE    = 2'd2;
	localparam logic [1:0] CMD_REALLOC = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_ROOM   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic [1:0] REG_HEAP_TOP    = 2'd0;
	localparam logic [1:0] REG_HEAP_FLOOR  = 2'd1;
	localparam logic [1:0] REG_HEADER_SIZE = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [30:0] request_size;
		logic [31:0] pointer_in;
		logic [30:0] timer_now;
	} in_item_t;

	typedef struct packed {
		logic [31:0] pointer_out;
		logic [1:0]  status;
		logic [30:0] copy_length;
	} out_item_t;

	typedef struct packed {
		logic [31:0]       addr;
		logic [30:0]       size;
		logic [LINK_W-1:0] link;
	} entry_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		entry_t           wr_data;
	} ram_req_t;

endpackage

@@ rtl/ffba_entry_ram.sv @@
// Block table memory: address, size and link of every entry, one read and one write port.
module ffba_entry_ram import ffba_pkg::*; (
	input  logic     clk,
	input  ram_req_t req,
	output entry_t   rd_data
);

	entry_t mem [MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_idx] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_idx];
		end
	end

endmodule

@@ rtl/first_fit_block_allocator.sv @@
// Top level of the first-fit block allocator: command sequencer and block flags.
//
//  channel | signals                    | direction | accepted when
//  input   | in_valid, in_stall, in_item | in        | in_valid && !in_stall
//  output  | out_valid, out_stall, out_item | out    | out_valid && !out_stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in | cfg_valid && cfg_ready
//
// One item at a time. Each table walk reads the entry memory for every visited block
// and then evaluates it; an auto sweep walks the same way and frees each auto block
// it finds, merging it with a free successor. A moving realloc walks twice, once to
// find the old block and once to allocate, and then frees the old block.
// Reset clears all flags at once; the entry memory needs no clearing pass.
// A finished result waits in the output register while the next item is accepted.
module first_fit_block_allocator import ffba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [14:0] {
		S_IDLE   = 15'b000000000000001,
		S_SW_RD  = 15'b000000000000010,
		S_SW_EV  = 15'b000000000000100,
		S_FB_RD0 = 15'b000000000001000,
		S_FB_WT  = 15'b000000000010000,
		S_FB_EV  = 15'b000000000100000,
		S_AL_RD  = 15'b000000001000000,
		S_AL_EV  = 15'b000000010000000,
		S_AL_SPL = 15'b000000100000000,
		S_GR_RD  = 15'b000001000000000,
		S_GR_EV  = 15'b000010000000000,
		S_AL_DN  = 15'b000100000000000,
		S_FD_RD  = 15'b001000000000000,
		S_FD_EV  = 15'b010000000000000,
		S_OUT    = 15'b100000000000000
	} state_t;

	state_t state_q;

	logic [31:0] heap_top_q, heap_floor_q;
	logic [4:0]  hdr_q;
	logic [MAX_BLOCKS-1:0] busy_q, used_q, auto_q;
	logic [LINK_W-1:0] lowest_q, cur_q, cnt_q, free_slot_q, fb_i_q, b_q, old_q;
	logic [30:0] last_tick_q, old_size_q;
	logic        fb_sweep_q, alloc_ok_q;
	in_item_t    req_q;
	entry_t      fb_ent_q, split_ent_q;
	logic [31:0] res_pout_q;
	logic [1:0]  res_status_q;
	logic [30:0] res_copy_q;
	logic        out_valid_q;
	out_item_t   out_q;

	ram_req_t ram_req;
	entry_t   rdata;

	logic [LINK_W-1:0] fs;
	logic        walk_end, fit, split, grow_ok, moving, merge_go;
	logic [30:0] rest;
	logic [31:0] need, base, grow_addr, addr_hdr, split_min;
	logic [32:0] merge_sum;
	logic [30:0] merge_size;
	logic [IDX_W-1:0] cur_idx;

	ffba_entry_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rdata)
	);

	always_comb begin
		fs = NIL;
		for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				fs = LINK_W'(i);
			end
		end
	end

	assign cur_idx   = cur_q[IDX_W-1:0];
	assign walk_end  = (cnt_q == WALK_LIMIT) || (cur_q == NIL);
	assign addr_hdr  = rdata.addr + {27'b0, hdr_q};
	assign fit       = !used_q[cur_idx] && (req_q.request_size <= rdata.size);
	assign rest      = rdata.size - req_q.request_size;
	assign split_min = {27'b0, hdr_q} + 32'(MIN_SPLIT_EXTRA);
	assign split     = ({1'b0, rest} >= split_min) && (free_slot_q != NIL);
	assign need      = {1'b0, req_q.request_size} + {27'b0, hdr_q};
	assign base      = (lowest_q != NIL) ? rdata.addr : heap_top_q;
	assign grow_addr = base - need;
	assign grow_ok   = !(need > base) && (grow_addr >= heap_floor_q);
	assign moving    = (req_q.command == CMD_REALLOC) && (req_q.pointer_in != 32'd0);
	assign merge_go  = (rdata.link != NIL) && !used_q[rdata.link[IDX_W-1:0]];
	assign merge_sum = {2'b0, fb_ent_q.size} + {2'b0, rdata.size} + {28'b0, hdr_q};
	assign merge_size = (merge_sum > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : merge_sum[30:0];

	always_comb begin
		ram_req = '0;
		case (state_q)
			S_SW_RD, S_AL_RD, S_FD_RD: begin
				ram_req.rd_en  = !walk_end;
				ram_req.rd_idx = cur_idx;
			end
			S_FB_RD0: begin
				ram_req.rd_en  = 1'b1;
				ram_req.rd_idx = fb_i_q[IDX_W-1:0];
			end
			S_FB_WT: begin
				ram_req.rd_en  = merge_go;
				ram_req.rd_idx = rdata.link[IDX_W-1:0];
			end
			S_GR_RD: begin
				ram_req.rd_en  = lowest_q != NIL;
				ram_req.rd_idx = lowest_q[IDX_W-1:0];
			end
			S_FB_EV: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_idx  = fb_i_q[IDX_W-1:0];
				ram_req.wr_data = '{addr: fb_ent_q.addr, size: merge_size, link: rdata.link};
			end
			S_AL_EV: begin
				ram_req.wr_en   = fit && split;
				ram_req.wr_idx  = free_slot_q[IDX_W-1:0];
				ram_req.wr_data = '{addr: addr_hdr + {1'b0, req_q.request_size},
					size: rest - {26'b0, hdr_q}, link: rdata.link};
			end
			S_AL_SPL: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_idx  = cur_idx;
				ram_req.wr_data = split_ent_q;
			end
			S_GR_EV: begin
				ram_req.wr_en   = grow_ok;
				ram_req.wr_idx  = free_slot_q[IDX_W-1:0];
				ram_req.wr_data = '{addr: grow_addr, size: req_q.request_size, link: lowest_q};
			end
			default: begin
				ram_req = '0;
			end
		endcase
	end

	assign in_stall  = state_q != S_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			heap_top_q   <= HEAP_TOP_RESET;
			heap_floor_q <= HEAP_FLOOR_RESET;
			hdr_q        <= HEADER_SIZE_RESET;
			busy_q       <= '0;
			used_q       <= '0;
			auto_q       <= '0;
			lowest_q     <= NIL;
			last_tick_q  <= '0;
			free_slot_q  <= '0;
			cur_q        <= NIL;
			cnt_q        <= '0;
			fb_i_q       <= '0;
			b_q          <= '0;
			old_q        <= '0;
			old_size_q   <= '0;
			fb_sweep_q   <= 1'b0;
			alloc_ok_q   <= 1'b0;
			req_q        <= '0;
			fb_ent_q     <= '0;
			split_ent_q  <= '0;
			res_pout_q   <= '0;
			res_status_q <= ST_OK;
			res_copy_q   <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			free_slot_q <= fs;
			if (cfg_valid) begin
				case (cfg_index)
					REG_HEAP_TOP:    heap_top_q   <= cfg_data;
					REG_HEAP_FLOOR:  heap_floor_q <= cfg_data;
					REG_HEADER_SIZE: hdr_q        <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q        <= in_item;
						cur_q        <= lowest_q;
						cnt_q        <= '0;
						res_pout_q   <= '0;
						res_status_q <= ST_OK;
						res_copy_q   <= '0;
						fb_sweep_q   <= 1'b0;
						case (in_item.command)
							CMD_ALLOC: state_q <= S_AL_RD;
							CMD_AUTO: begin
								last_tick_q <= in_item.timer_now;
								state_q <= (last_tick_q > in_item.timer_now) ? S_SW_RD : S_AL_RD;
							end
							CMD_FREE: begin
								state_q <= (in_item.pointer_in == 32'd0) ? S_OUT : S_FD_RD;
							end
							default: begin
								if (in_item.pointer_in != 32'd0) begin
									state_q <= S_FD_RD;
								end else if (in_item.request_size != 31'd0) begin
									state_q <= S_AL_RD;
								end else begin
									state_q <= S_OUT;
								end
							end
						endcase
					end
				end
				S_SW_RD: begin
					if (walk_end) begin
						cur_q   <= lowest_q;
						cnt_q   <= '0;
						state_q <= S_AL_RD;
					end else begin
						state_q <= S_SW_EV;
					end
				end
				S_SW_EV: begin
					cnt_q <= cnt_q + 1'b1;
					if (used_q[cur_idx] && auto_q[cur_idx]) begin
						fb_i_q     <= cur_q;
						fb_sweep_q <= 1'b1;
						state_q    <= S_FB_WT;
					end else begin
						cur_q   <= rdata.link;
						state_q <= S_SW_RD;
					end
				end
				S_FB_RD0: begin
					state_q <= S_FB_WT;
				end
				S_FB_WT: begin
					fb_ent_q <= rdata;
					if (merge_go) begin
						state_q <= S_FB_EV;
					end else begin
						used_q[fb_i_q[IDX_W-1:0]] <= 1'b0;
						auto_q[fb_i_q[IDX_W-1:0]] <= 1'b0;
						cur_q   <= rdata.link;
						state_q <= fb_sweep_q ? S_SW_RD : S_OUT;
					end
				end
				S_FB_EV: begin
					busy_q[fb_ent_q.link[IDX_W-1:0]] <= 1'b0;
					auto_q[fb_ent_q.link[IDX_W-1:0]] <= 1'b0;
					used_q[fb_i_q[IDX_W-1:0]] <= 1'b0;
					auto_q[fb_i_q[IDX_W-1:0]] <= 1'b0;
					cur_q   <= rdata.link;
					state_q <= fb_sweep_q ? S_SW_RD : S_OUT;
				end
				S_AL_RD: begin
					state_q <= walk_end ? S_GR_RD : S_AL_EV;
				end
				S_AL_EV: begin
					cnt_q <= cnt_q + 1'b1;
					if (fit) begin
						used_q[cur_idx] <= 1'b1;
						b_q        <= cur_q;
						alloc_ok_q <= 1'b1;
						res_pout_q <= addr_hdr;
						if (split) begin
							busy_q[free_slot_q[IDX_W-1:0]] <= 1'b1;
							used_q[free_slot_q[IDX_W-1:0]] <= 1'b0;
							auto_q[free_slot_q[IDX_W-1:0]] <= 1'b0;
							split_ent_q <= '{addr: rdata.addr, size: req_q.request_size,
								link: free_slot_q};
							state_q <= S_AL_SPL;
						end else begin
							state_q <= S_AL_DN;
						end
					end else begin
						cur_q   <= rdata.link;
						state_q <= S_AL_RD;
					end
				end
				S_AL_SPL: begin
					state_q <= S_AL_DN;
				end
				S_GR_RD: begin
					if (free_slot_q == NIL) begin
						alloc_ok_q <= 1'b0;
						state_q    <= S_AL_DN;
					end else begin
						state_q <= S_GR_EV;
					end
				end
				S_GR_EV: begin
					alloc_ok_q <= grow_ok;
					if (grow_ok) begin
						busy_q[free_slot_q[IDX_W-1:0]] <= 1'b1;
						used_q[free_slot_q[IDX_W-1:0]] <= 1'b1;
						auto_q[free_slot_q[IDX_W-1:0]] <= 1'b0;
						lowest_q   <= free_slot_q;
						b_q        <= free_slot_q;
						res_pout_q <= grow_addr + {27'b0, hdr_q};
					end
					state_q <= S_AL_DN;
				end
				S_AL_DN: begin
					if (alloc_ok_q) begin
						if (req_q.command == CMD_AUTO) begin
							auto_q[b_q[IDX_W-1:0]] <= 1'b1;
						end
						if (moving) begin
							res_copy_q <= old_size_q;
							fb_i_q     <= old_q;
							fb_sweep_q <= 1'b0;
							state_q    <= S_FB_RD0;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						res_pout_q   <= '0;
						res_status_q <= ST_NO_ROOM;
						state_q      <= S_OUT;
					end
				end
				S_FD_RD: begin
					if (walk_end) begin
						res_status_q <= ST_NOT_FOUND;
						state_q      <= S_OUT;
					end else begin
						state_q <= S_FD_EV;
					end
				end
				S_FD_EV: begin
					cnt_q <= cnt_q + 1'b1;
					if (addr_hdr == req_q.pointer_in) begin
						old_q      <= cur_q;
						old_size_q <= rdata.size;
						if (req_q.command == CMD_FREE || req_q.request_size == 31'd0) begin
							fb_i_q  <= cur_q;
							state_q <= S_FB_WT;
						end else if (rdata.size >= req_q.request_size) begin
							res_pout_q <= req_q.pointer_in;
							state_q    <= S_OUT;
						end else begin
							cur_q   <= lowest_q;
							cnt_q   <= '0;
							state_q <= S_AL_RD;
						end
					end else begin
						cur_q   <= rdata.link;
						state_q <= S_FD_RD;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_q       <= '{pointer_out: res_pout_q, status: res_status_q,
							copy_length: res_copy_q};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_used_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q & ~busy_q) == '0)
		else $error("A used block sits in a free slot.");

	a_auto_used: assert property (@(posedge clk) disable iff (!arst_n)
		(auto_q & ~used_q) == '0)
		else $error("An auto flag is set on a block that is not in use.");

	a_lowest_busy: assert property (@(posedge clk) disable iff (!arst_n)
		lowest_q != NIL |-> busy_q[lowest_q[IDX_W-1:0]])
		else $error("The lowest block points at a free slot.");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q != S_IDLE)
		else $error("An accepted item did not start work.");

endmodule
